### hw/rtl/npq_pkg.sv
// ----------------------------------------------------------------------------
// npq_pkg
// Shared types, palette table and distance function for the nearest palette
// quantizer.
// ----------------------------------------------------------------------------
package npq_pkg;

  localparam int NUM_COLORS = 16;
  localparam int IDX_W      = $clog2(NUM_COLORS);
  localparam int CH_W       = 8;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = SQ_W + 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic   valid;
    color_t first_pix;
    color_t second_pix;
    dist_t  first_dist;
    dist_t  second_dist;
    idx_t   first_idx;
    idx_t   second_idx;
  } stage_t;

  localparam dist_t DIST_MAX = {DIST_W{1'b1}};

  localparam color_t PALETTE [NUM_COLORS] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'h00, 8'hA1, 8'hFF},
    '{8'h9F, 8'hA0, 8'hFF}, '{8'h00, 8'hFF, 8'hFF}, '{8'h00, 8'hA0, 8'hA3},
    '{8'h00, 8'hA1, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h9D, 8'hFF, 8'hA0},
    '{8'h9B, 8'h00, 8'h00}, '{8'hFF, 8'h00, 8'h00}, '{8'hFF, 8'h00, 8'hA2},
    '{8'hFF, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00}, '{8'h9F, 8'hA1, 8'hA2},
    '{8'hFF, 8'hFF, 8'hFF}
  };

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  function automatic dist_t sq_dist(input color_t p, input color_t c);
    return DIST_W'(sq_diff(p.blue, c.blue)) + DIST_W'(sq_diff(p.green, c.green))
         + DIST_W'(sq_diff(p.red, c.red));
  endfunction

endpackage

### hw/rtl/npq_cell.sv
// ----------------------------------------------------------------------------
// npq_cell
// One palette entry of the chain: measures both pixels against its color and
// keeps the nearer candidate, then hands the request to the next cell.
// ----------------------------------------------------------------------------
module npq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  npq_pkg::color_t pal_color,
  input  npq_pkg::idx_t   pal_idx,
  input  npq_pkg::stage_t stage_in,
  output npq_pkg::stage_t stage_out
);

  npq_pkg::stage_t stage_r;
  npq_pkg::stage_t stage_nxt;
  npq_pkg::dist_t  first_d;
  npq_pkg::dist_t  second_d;

  always_comb begin
    first_d   = npq_pkg::sq_dist(stage_in.first_pix, pal_color);
    second_d  = npq_pkg::sq_dist(stage_in.second_pix, pal_color);
    stage_nxt = stage_in;
    if (first_d < stage_in.first_dist) begin
      stage_nxt.first_dist = first_d;
      stage_nxt.first_idx  = pal_idx;
    end
    if (second_d < stage_in.second_dist) begin
      stage_nxt.second_dist = second_d;
      stage_nxt.second_idx  = pal_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

### hw/rtl/nearest_palette_quantizer_4bpp_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_quantizer_4bpp_unit
// Maps each pixel of a BGR pair to its nearest 16-color palette entry and
// packs the two indices into one byte.
//
// Usage:
//   A request (two 24-bit pixels) is taken at a rising edge with start high
//   and busy low. busy is always low: one request is taken every cycle.
//   Each request runs through a chain of 16 cells, one per palette entry;
//   each cell compares both pixels with its entry and keeps the nearer
//   candidate, the lower index winning ties.
//   Each cell registers its result; out_strobe rises when a request leaves the
//   last cell's register. Throughput: one request per cycle.
//   out_packed_indices holds the first pixel's index in bits 7..4 and the
//   second's in bits 3..0, valid for the single cycle out_strobe is high.
//   The receiver cannot stall; results are presented once and then dropped.
//   Reset clears all cell valid flags; requests in flight are discarded.
// ----------------------------------------------------------------------------
module nearest_palette_quantizer_4bpp_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_first_blue,
  input  logic [7:0] in_first_green,
  input  logic [7:0] in_first_red,
  input  logic [7:0] in_second_blue,
  input  logic [7:0] in_second_green,
  input  logic [7:0] in_second_red,
  output logic       out_strobe,
  output logic [7:0] out_packed_indices
);

  localparam int N = npq_pkg::NUM_COLORS;

  npq_pkg::stage_t chain [N+1];

  assign busy = 1'b0;

  always_comb begin
    chain[0].valid             = start;
    chain[0].first_pix.blue    = in_first_blue;
    chain[0].first_pix.green   = in_first_green;
    chain[0].first_pix.red     = in_first_red;
    chain[0].second_pix.blue   = in_second_blue;
    chain[0].second_pix.green  = in_second_green;
    chain[0].second_pix.red    = in_second_red;
    chain[0].first_dist        = npq_pkg::DIST_MAX;
    chain[0].second_dist       = npq_pkg::DIST_MAX;
    chain[0].first_idx         = '0;
    chain[0].second_idx        = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    npq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pal_color (npq_pkg::PALETTE[k]),
      .pal_idx   (npq_pkg::IDX_W'(k)),
      .stage_in  (chain[k]),
      .stage_out (chain[k+1])
    );
  end

  assign out_strobe         = chain[N].valid;
  assign out_packed_indices = {chain[N].first_idx, chain[N].second_idx};

  a_strobe_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, N))
    else $error("result without matching request");

  a_chain_advance: assert property (@(posedge clk) disable iff (!rst_n)
    chain[N-1].valid |=> out_strobe)
    else $error("request lost in last cell");

  a_dist_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (chain[N].first_dist != npq_pkg::DIST_MAX)
                && (chain[N].second_dist != npq_pkg::DIST_MAX))
    else $error("no palette entry selected");

endmodule
